FILE: rtl/cfmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmm_pkg: shared types and codes for the circular FIFO with min/max scan
// Operation and status codes, and the control bundle that drives the
// compare unit.
// ----------------------------------------------------------------------------
package cfmm_pkg;

   localparam int WORD_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 8;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCAN = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // head value reported for an empty queue
   localparam logic [WORD_W-1:0] EMPTY_HEAD = '1;

   // control for the compare unit
   typedef struct packed {
      logic en;     // a read word is present this cycle
      logic first;  // word is the first of the scan: load, do not compare
   } mm_ctrl_type;

endpackage

FILE: rtl/circular_fifo_with_min_max_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_min_max_scan: ring-buffer FIFO of signed words
// Push, pop or scan for the largest and smallest stored word; every
// operation returns status, head value and entry count.
// ----------------------------------------------------------------------------
// Channel   Ports                                     Handshake
// request   req_kind, req_value                       start & !busy
// response  rsp_status, rsp_head_value, rsp_entry_count,
//           rsp_largest, rsp_smallest                 rsp_valid strobe
//
// Push, pop and no-op pass through EXEC, HEAD and WAIT; the response strobe
// is registered as WAIT ends, on the same edge that returns to IDLE.
// A scan runs SCAN after EXEC while stored words remain, then DRAIN; the single
// RAM read port walks the entries one per cycle into the compare unit.
// Reset clears head, tail and count; the RAM contents are not cleared.
// The receiver cannot stall; busy stays high from accept until the strobe.
// ----------------------------------------------------------------------------
module circular_fifo_with_min_max_scan #(
   parameter int DEPTH = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cfmm_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cfmm_pkg::WORD_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic [cfmm_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [cfmm_pkg::WORD_W-1:0]   rsp_head_value,
   output logic [cfmm_pkg::COUNT_W-1:0]         rsp_entry_count,
   output logic signed [cfmm_pkg::WORD_W-1:0]   rsp_largest,
   output logic signed [cfmm_pkg::WORD_W-1:0]   rsp_smallest
);
   import cfmm_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_COUNT  = CW'(1);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_HEAD  = 6'b010000,
      ST_WAIT  = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [AW-1:0]            tail_ff, tail_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]            scan_left_ff, scan_left_in;
   logic                     data_vld_ff, data_vld_in;
   logic                     first_ff, first_in;
   logic                     scan_ok_ff, scan_ok_in;
   logic [KIND_W-1:0]        kind_ff, kind_in;
   logic [WORD_W-1:0]        value_ff, value_in;
   logic [STATUS_W-1:0]      status_ff, status_in;

   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [WORD_W-1:0]        rsp_head_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic [WORD_W-1:0]        rsp_largest_ff;
   logic [WORD_W-1:0]        rsp_smallest_ff;

   logic                     wr_en;
   logic [AW-1:0]            rd_addr;
   logic [WORD_W-1:0]        rd_data;
   mm_ctrl_type              mm_ctrl;
   logic signed [WORD_W-1:0] mm_largest;
   logic signed [WORD_W-1:0] mm_smallest;

   // entry storage
   cfmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compare unit
   assign mm_ctrl.en    = data_vld_ff;
   assign mm_ctrl.first = first_ff;

   cfmm_minmax u_minmax (
      .clock    (clock),
      .ctrl     (mm_ctrl),
      .data     (rd_data),
      .largest  (mm_largest),
      .smallest (mm_smallest)
   );

   // walk the scan pointer while scanning, else read the head
   assign rd_addr = (state_ff == ST_SCAN) ? scan_ptr_ff : head_ff;
   assign wr_en   = (state_ff == ST_EXEC) && (kind_ff == KIND_PUSH)
                    && (count_ff != FULL_COUNT);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_left_in = scan_left_ff;
      first_in     = first_ff;
      scan_ok_in   = scan_ok_ff;
      kind_in      = kind_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      data_vld_in  = (state_ff == ST_SCAN);
      if (data_vld_ff) begin
         first_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               value_in = req_value;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            status_in  = STATUS_DONE;
            scan_ok_in = 1'b0;
            state_in   = ST_HEAD;
            case (kind_ff)
               KIND_PUSH: begin
                  if (count_ff == FULL_COUNT) begin
                     status_in = STATUS_FULL;
                  end else begin
                     tail_in  = tail_ff + AW'(1);
                     count_in = count_ff + ONE_COUNT;
                  end
               end
               KIND_POP: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     head_in  = head_ff + AW'(1);
                     count_in = count_ff - ONE_COUNT;
                  end
               end
               KIND_SCAN: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                  end else begin
                     scan_ok_in   = 1'b1;
                     scan_ptr_in  = head_ff;
                     scan_left_in = count_ff;
                     first_in     = 1'b1;
                     state_in     = ST_SCAN;
                  end
               end
               default: begin
                  status_in = STATUS_DONE;
               end
            endcase
         end
         ST_SCAN: begin
            scan_ptr_in  = scan_ptr_ff + AW'(1);
            scan_left_in = scan_left_ff - ONE_COUNT;
            if (scan_left_ff == ONE_COUNT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         data_vld_ff <= 1'b0;
         first_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         data_vld_ff <= data_vld_in;
         first_ff    <= first_in;
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      scan_ptr_ff  <= scan_ptr_in;
      scan_left_ff <= scan_left_in;
      scan_ok_ff   <= scan_ok_in;
      kind_ff      <= kind_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
   end

   // response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == ST_WAIT);
      end
   end

   // capture the response once the head word is back from the RAM
   always_ff @(posedge clock) begin
      if (state_ff == ST_WAIT) begin
         rsp_status_ff   <= status_ff;
         rsp_head_ff     <= (count_ff == '0) ? EMPTY_HEAD : rd_data;
         rsp_count_ff    <= COUNT_W'(count_ff);
         rsp_largest_ff  <= scan_ok_ff ? mm_largest : '0;
         rsp_smallest_ff <= scan_ok_ff ? mm_smallest : '0;
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_value  = rsp_head_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_largest     = rsp_largest_ff;
   assign rsp_smallest    = rsp_smallest_ff;

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above capacity");

   a_ptr_distance: assert property (@(posedge clock) disable iff (reset)
      AW'(tail_ff - head_ff) == count_ff[AW-1:0])
      else $error("head/tail distance disagrees with entry count");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe outside idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");
`endif

endmodule

FILE: rtl/cfmm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module cfmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cfmm_minmax.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmm_minmax: running largest/smallest compare unit
// Takes one word per enabled cycle and keeps the signed extremes seen.
// ----------------------------------------------------------------------------
module cfmm_minmax (
   input  logic                                clock,
   input  cfmm_pkg::mm_ctrl_type               ctrl,
   input  logic signed [cfmm_pkg::WORD_W-1:0]  data,
   output logic signed [cfmm_pkg::WORD_W-1:0]  largest,
   output logic signed [cfmm_pkg::WORD_W-1:0]  smallest
);
   import cfmm_pkg::*;

   logic signed [WORD_W-1:0] largest_ff;
   logic signed [WORD_W-1:0] smallest_ff;
   logic signed [WORD_W-1:0] largest_in;
   logic signed [WORD_W-1:0] smallest_in;

   // load on the first word, otherwise keep the extremes
   always_comb begin
      largest_in  = largest_ff;
      smallest_in = smallest_ff;
      if (ctrl.en) begin
         if (ctrl.first) begin
            largest_in  = data;
            smallest_in = data;
         end else begin
            if (data > largest_ff) begin
               largest_in = data;
            end
            if (data < smallest_ff) begin
               smallest_in = data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      largest_ff  <= largest_in;
      smallest_ff <= smallest_in;
   end

   assign largest  = largest_ff;
   assign smallest = smallest_ff;

endmodule

FILE: verif/circular_fifo_with_min_max_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_min_max_scan_checker: response checker for the FIFO
// Watches every request transfer, runs its own copy of the ring buffer to
// work out the response, and compares each response strobe field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module circular_fifo_with_min_max_scan_checker #(
   parameter int DEPTH = 128
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [cfmm_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [cfmm_pkg::WORD_W-1:0]   req_value,
   input  logic                                 rsp_valid,
   input  logic [cfmm_pkg::STATUS_W-1:0]        rsp_status,
   input  logic signed [cfmm_pkg::WORD_W-1:0]   rsp_head_value,
   input  logic [cfmm_pkg::COUNT_W-1:0]         rsp_entry_count,
   input  logic signed [cfmm_pkg::WORD_W-1:0]   rsp_largest,
   input  logic signed [cfmm_pkg::WORD_W-1:0]   rsp_smallest,
   output int                                   fail_count,
   output int                                   pending_results
);
   import cfmm_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [WORD_W-1:0] head_value;
      logic [COUNT_W-1:0]       entry_count;
      logic signed [WORD_W-1:0] largest;
      logic signed [WORD_W-1:0] smallest;
   } fifo_response_type;

   // shadow copy of the ring buffer
   logic signed [WORD_W-1:0] word_store [DEPTH];
   int unsigned              head_idx;
   int unsigned              tail_idx;
   int unsigned              word_count;

   fifo_response_type        expected_q[$];

   // apply one operation to the shadow buffer and return its response
   function automatic fifo_response_type apply_op(input logic [KIND_W-1:0] kind,
                                                  input logic signed [WORD_W-1:0] value);
      fifo_response_type resp;
      int unsigned       pos;
      resp = '0;
      resp.status = STATUS_DONE;
      case (kind)
         KIND_PUSH: begin
            if (word_count >= DEPTH) begin
               resp.status = STATUS_FULL;
            end else begin
               word_store[tail_idx] = value;
               tail_idx = (tail_idx + 1) % DEPTH;
               word_count++;
            end
         end
         KIND_POP: begin
            if (word_count == 0) begin
               resp.status = STATUS_EMPTY;
            end else begin
               head_idx = (head_idx + 1) % DEPTH;
               word_count--;
            end
         end
         KIND_SCAN: begin
            if (word_count == 0) begin
               resp.status = STATUS_EMPTY;
            end else begin
               pos = head_idx;
               resp.largest = word_store[pos];
               resp.smallest = word_store[pos];
               for (int unsigned i = 1; i < word_count; i++) begin
                  pos = (pos + 1) % DEPTH;
                  if (word_store[pos] > resp.largest) resp.largest = word_store[pos];
                  if (word_store[pos] < resp.smallest) resp.smallest = word_store[pos];
               end
            end
         end
         default: ;  // unused kind leaves the queue alone
      endcase
      resp.head_value = (word_count == 0) ? EMPTY_HEAD : word_store[head_idx];
      resp.entry_count = word_count[COUNT_W-1:0];
      return resp;
   endfunction

   // report one field and return 1 on a mismatch
   function automatic int field_mismatch(input string name,
                                         input logic signed [WORD_W-1:0] want,
                                         input logic signed [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // check response transfers, then predict newly accepted requests
   always @(posedge clock) begin
      fifo_response_type want;
      int                errs;
      errs = 0;
      if (reset) begin
         head_idx = 0;
         tail_idx = 0;
         word_count = 0;
         expected_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (expected_q.size() == 0) begin
               $error("response with nothing outstanding: status %0d head %0d",
                      rsp_status, rsp_head_value);
               errs++;
            end else begin
               want = expected_q.pop_front();
               errs += field_mismatch("status", want.status, rsp_status);
               errs += field_mismatch("head_value", want.head_value, rsp_head_value);
               errs += field_mismatch("entry_count", want.entry_count, rsp_entry_count);
               errs += field_mismatch("largest", want.largest, rsp_largest);
               errs += field_mismatch("smallest", want.smallest, rsp_smallest);
            end
         end
         if (start && busy === 1'b0) begin
            expected_q.push_back(apply_op(req_kind, req_value));
         end
      end
      fail_count <= fail_count + errs;
      pending_results <= expected_q.size();
   end

endmodule

FILE: verif/circular_fifo_with_min_max_scan_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_min_max_scan_tb: stimulus and verdict for the FIFO
// Runs a directed sequence over empty, extreme and no-op cases, then random
// fill, drain and mixed phases that wrap the ring and hit the full limit,
// with random request gaps. The checker predicts and compares.
// ----------------------------------------------------------------------------
module circular_fifo_with_min_max_scan_tb;
   import cfmm_pkg::*;

   localparam int                DEPTH         = 128;
   localparam int                RANDOM_OPS    = 1700;
   localparam int                CYCLE_LIMIT   = 1000000;
   localparam int                DRAIN_CYCLES  = 12;
   localparam logic [KIND_W-1:0] KIND_NOOP     = 2'd3;

   // phase styles of the random part
   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_style_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [KIND_W-1:0]          req_kind = '0;
   logic signed [WORD_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic [STATUS_W-1:0]        rsp_status;
   logic signed [WORD_W-1:0]   rsp_head_value;
   logic [COUNT_W-1:0]         rsp_entry_count;
   logic signed [WORD_W-1:0]   rsp_largest;
   logic signed [WORD_W-1:0]   rsp_smallest;
   int                         fail_count;
   int                         pending_results;
   int                         cycle_count = 0;
   bit                         steady = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   circular_fifo_with_min_max_scan #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_value  (rsp_head_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_largest     (rsp_largest),
      .rsp_smallest    (rsp_smallest)
   );

   circular_fifo_with_min_max_scan_checker #(.DEPTH(DEPTH)) fifo_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_value  (rsp_head_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_largest     (rsp_largest),
      .rsp_smallest    (rsp_smallest),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("circular_fifo_with_min_max_scan test failed");
         $finish;
      end
   end

   // hold start low for a random gap, then drive one request until transfer
   task automatic send_op(input logic [KIND_W-1:0] kind,
                          input logic signed [WORD_W-1:0] value);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // word with a bias toward the signed extremes and small values
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return $signed($urandom_range(0, 20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   // pick the next operation for the current phase style
   function automatic logic [KIND_W-1:0] pick_kind(input phase_style_type style);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return KIND_NOOP;
      case (style)
         PHASE_FILL:  return (roll < 87) ? KIND_PUSH : (roll < 92) ? KIND_POP : KIND_SCAN;
         PHASE_DRAIN: return (roll < 82) ? KIND_POP : (roll < 90) ? KIND_PUSH : KIND_SCAN;
         default:     return (roll < 48) ? KIND_PUSH : (roll < 88) ? KIND_POP : KIND_SCAN;
      endcase
   endfunction

   initial begin
      int              issued;
      int              phase_len;
      phase_style_type style;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty queue, extremes, unused kind, empty head after -1
      send_op(KIND_SCAN, 32'sd5);
      send_op(KIND_POP, -32'sd1);
      send_op(KIND_NOOP, 32'sh7FFF_FFFF);
      send_op(KIND_PUSH, 32'sh7FFF_FFFF);
      send_op(KIND_PUSH, 32'sh8000_0000);
      send_op(KIND_PUSH, -32'sd1);
      send_op(KIND_PUSH, 32'sd0);
      send_op(KIND_SCAN, 32'sh8000_0000);
      send_op(KIND_NOOP, -32'sd1);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_SCAN, 32'sd0);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_SCAN, 32'sd0);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_SCAN, 32'sd0);
      send_op(KIND_PUSH, -32'sd1);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_PUSH, 32'sh5555_5555);
      send_op(KIND_PUSH, 32'shAAAA_AAAA);
      send_op(KIND_SCAN, 32'shFFFF_FFFF);
      send_op(KIND_NOOP, $urandom);
      send_op(KIND_POP, 32'sd0);
      send_op(KIND_POP, 32'sd0);

      // random phases: long fills reach full, drains reach empty
      issued = 0;
      while (issued < RANDOM_OPS) begin
         case ($urandom_range(0, 2))
            0: style = PHASE_FILL;
            1: style = PHASE_DRAIN;
            default: style = PHASE_MIXED;
         endcase
         phase_len = (style == PHASE_FILL) ? $urandom_range(150, 260)
                                           : $urandom_range(20, 180);
         steady = ($urandom_range(0, 3) == 0);
         // cut the last phase short at the item budget
         while ((phase_len > 0) && (issued < RANDOM_OPS)) begin
            send_op(pick_kind(style), pick_word());
            issued++;
            phase_len--;
         end
      end

      // drop start and wait out outstanding responses
      start <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("circular_fifo_with_min_max_scan test passed");
      end else begin
         $display("circular_fifo_with_min_max_scan test failed");
      end
      $finish;
   end

endmodule
